// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed on page frame manager ports");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed on page frame manager ports");

`endif

// ===== src/pfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpm_pkg
// Types and codes shared by the page frame manager files.
// ----------------------------------------------------------------------------
package pfpm_pkg;

  localparam int FRAMES_DEFAULT = 16;

  // Commands
  localparam logic [2:0] CMD_PIN   = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_DIRTY = 3'd2;
  localparam logic [2:0] CMD_UNPIN = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;
  localparam logic [2:0] CMD_FORCE = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_FINAL = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOBUF    = 2'd1;
  localparam logic [1:0] ST_INBUF    = 2'd2;
  localparam logic [1:0] ST_NOTINBUF = 2'd3;

  localparam logic [7:0] PIN_MAX = 8'hFF;

  // One frame's stored tag and bookkeeping
  typedef struct packed {
    logic [7:0]  file;
    logic [15:0] page;
    logic [7:0]  pin;
    logic        dirty;
  } frame_t;

  // Write request into the frame store
  typedef struct packed {
    logic   en;
    frame_t data;
  } store_wr_t;

  // One result item before packing onto the stream
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  frame;
    logic [7:0]  file;
    logic [15:0] page;
    logic [1:0]  status;
    logic        last;
  } item_t;

endpackage

// ===== src/pfpm_frame_store.sv =====
// ----------------------------------------------------------------------------
// pfpm_frame_store
// Frame tag memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfpm_frame_store import pfpm_pkg::*; #(
  parameter int FRAMES = FRAMES_DEFAULT,
  localparam int IW = $clog2(FRAMES)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output frame_t        rd_data,
  input  store_wr_t     wr,
  input  logic [IW-1:0] wr_addr
);

  frame_t mem [FRAMES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/page_frame_pin_manager.sv =====
// ----------------------------------------------------------------------------
// page_frame_pin_manager
// Buffer pool frame manager with pin counts, dirty marks and eviction.
//
// Each input item carries one command (pin/get, alloc, mark dirty, unpin,
// flush file, force pages) and produces zero or more write-back and read
// requests followed by exactly one final status item with tlast set. The
// block walks the frame table one frame at a time (S_RD reads the tag
// memory, S_EV runs the single tag comparator), and the walk holds on a
// frame while its write-back waits for the output side. An unknown command
// skips the walk and only reports status. s_tready is high only while no
// command is in progress; the last result may still wait in the output
// register while the next command is accepted. No clearing pass is needed
// after reset: frame valid bits live in flip-flops and reset frees every
// frame at once.
// ----------------------------------------------------------------------------
module page_frame_pin_manager import pfpm_pkg::*; #(
  parameter int FRAMES = FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // command items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // file_id[7:0], page_number[23:8], all_pages[24], zero
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // frame_index[3:0], out_file_id[11:4],
                                 // out_page_number[27:12], status[29:28], zero
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  localparam int IW = $clog2(FRAMES);
  localparam logic [IW-1:0] LAST_FRAME = IW'(FRAMES - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a command
  localparam logic [2:0] S_RD   = 3'd1;  // read one frame's tag
  localparam logic [2:0] S_EV   = 3'd2;  // compare and act on that frame
  localparam logic [2:0] S_DEC  = 3'd3;  // decide after a lookup scan
  localparam logic [2:0] S_WB   = 3'd4;  // issue a single write-back
  localparam logic [2:0] S_FILL = 3'd5;  // load the new tag into the victim
  localparam logic [2:0] S_RQ   = 3'd6;  // issue the read request
  localparam logic [2:0] S_FIN  = 3'd7;  // issue the final status

  function automatic logic [3:0] low4(input logic [IW-1:0] f);
    logic [IW+3:0] e;
    e = {4'b0000, f};
    return e[3:0];
  endfunction

  logic [2:0]    state;
  logic [IW-1:0] idx;

  // Latched command
  logic [2:0]  cmd_r;
  logic [7:0]  file_r;
  logic [15:0] page_r;
  logic        all_r;

  // Scan results
  logic          hit_f, free_f, unp_f;
  logic [IW-1:0] hit_idx, free_idx, unp_idx;
  frame_t        hd, ud;

  logic [IW-1:0] victim;
  logic [IW-1:0] frame_r;
  logic [1:0]    status_r;

  logic [IW-1:0] wb_idx;
  logic [7:0]    wb_file;
  logic [15:0]   wb_page;

  logic [FRAMES-1:0] valid;

  // Frame store
  frame_t        rd;
  store_wr_t     wr;
  logic [IW-1:0] wr_addr;

  pfpm_frame_store #(.FRAMES(FRAMES)) u_store (
    .clk     (clk),
    .rd_en   (state == S_RD),
    .rd_addr (idx),
    .rd_data (rd),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

  // ---------------------------------------------------------------------------
  // Shared tag comparator: one frame per visit of S_EV.
  // ---------------------------------------------------------------------------
  logic v_cur, file_eq, page_eq, tag_hit;
  logic last_frame;

  assign v_cur      = valid[idx];
  assign file_eq    = (rd.file == file_r);
  assign page_eq    = (rd.page == page_r);
  assign tag_hit    = v_cur && file_eq && page_eq;
  assign last_frame = (idx == LAST_FRAME);

  // Flush takes every valid frame of the file; force takes the dirty ones
  // whose page matches, or all of them when all_pages is set.
  logic flush_sel, force_sel, scan_wb;
  assign flush_sel = (cmd_r == CMD_FLUSH) && v_cur && file_eq;
  assign force_sel = (cmd_r == CMD_FORCE) && v_cur && file_eq &&
                     (all_r || page_eq) && rd.dirty;
  assign scan_wb   = (state == S_EV) && ((flush_sel && rd.dirty) || force_sel);

  // Output slot is free when empty or being drained this cycle.
  logic out_free, stall;
  assign out_free = !m_tvalid || m_tready;
  assign stall    = scan_wb && !out_free;

  // Pin count arithmetic on the hit frame
  logic [7:0] pin_inc, pin_dec;
  assign pin_inc = (hd.pin == PIN_MAX) ? PIN_MAX : hd.pin + 8'd1;
  assign pin_dec = (hd.pin == 8'd0) ? 8'd0 : hd.pin - 8'd1;

  // ---------------------------------------------------------------------------
  // Frame store write port
  // ---------------------------------------------------------------------------
  always_comb begin
    wr      = '0;
    wr_addr = idx;
    unique case (state)
      S_EV: begin
        if (!stall && flush_sel) begin
          // free the frame: clear pin count and dirty mark
          wr.en   = 1'b1;
          wr.data = '{file: rd.file, page: rd.page, pin: 8'd0, dirty: 1'b0};
        end else if (!stall && force_sel) begin
          wr.en   = 1'b1;
          wr.data = '{file: rd.file, page: rd.page, pin: rd.pin, dirty: 1'b0};
        end
      end
      S_DEC: begin
        wr_addr = hit_idx;
        if (hit_f) begin
          if (cmd_r == CMD_PIN) begin
            wr.en   = 1'b1;
            wr.data = '{file: hd.file, page: hd.page, pin: pin_inc, dirty: hd.dirty};
          end else if (cmd_r == CMD_DIRTY) begin
            wr.en   = 1'b1;
            wr.data = '{file: hd.file, page: hd.page, pin: hd.pin, dirty: 1'b1};
          end else if (cmd_r == CMD_UNPIN) begin
            // reaching zero writes a dirty page back, so it leaves clean
            wr.en   = 1'b1;
            wr.data = '{file: hd.file, page: hd.page, pin: pin_dec,
                        dirty: (pin_dec != 8'd0) && hd.dirty};
          end
        end
      end
      S_FILL: begin
        wr_addr = victim;
        wr.en   = 1'b1;
        wr.data = '{file: file_r, page: page_r, pin: 8'd1, dirty: 1'b0};
      end
      S_IDLE, S_RD, S_WB, S_RQ, S_FIN: begin
        wr = '0;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result item selection
  // ---------------------------------------------------------------------------
  logic  emit;
  item_t item;

  always_comb begin
    emit = 1'b0;
    item = '0;
    unique case (state)
      S_EV: begin
        emit = scan_wb;
        item = '{kind: KIND_WRITE, frame: low4(idx), file: rd.file, page: rd.page,
                 status: ST_OK, last: 1'b0};
      end
      S_WB: begin
        emit = 1'b1;
        item = '{kind: KIND_WRITE, frame: low4(wb_idx), file: wb_file, page: wb_page,
                 status: ST_OK, last: 1'b0};
      end
      S_RQ: begin
        emit = 1'b1;
        item = '{kind: KIND_READ, frame: low4(victim), file: file_r, page: page_r,
                 status: ST_OK, last: 1'b0};
      end
      S_FIN: begin
        emit = 1'b1;
        item = '{kind: KIND_FINAL, frame: low4(frame_r), file: file_r, page: page_r,
                 status: status_r, last: 1'b1};
      end
      S_IDLE, S_RD, S_DEC, S_FILL: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Output register: load when the slot frees, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      m_tdata <= {2'b00, item.status, item.page, item.file, item.frame};
      m_tuser <= item.kind;
      m_tlast <= item.last;
    end
  end

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Frame valid bits: reset frees every frame.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == S_EV && !stall && flush_sel) begin
      valid[idx] <= 1'b0;
    end else if (state == S_FILL) begin
      valid[victim] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      hit_f <= 1'b0;
      free_f <= 1'b0;
      unp_f <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r    <= s_tuser;
            file_r   <= s_tdata[7:0];
            page_r   <= s_tdata[23:8];
            all_r    <= s_tdata[24];
            frame_r  <= '0;
            status_r <= ST_OK;
            hit_f    <= 1'b0;
            free_f   <= 1'b0;
            unp_f    <= 1'b0;
            idx      <= '0;
            // unknown codes change nothing and only report status
            state    <= (s_tuser <= CMD_FORCE) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          // lookup commands track the first hit, first free and first
          // unpinned frame in one pass
          if (cmd_r <= CMD_UNPIN) begin
            if (tag_hit && !hit_f) begin
              hit_f   <= 1'b1;
              hit_idx <= idx;
              hd      <= rd;
            end
            if (!v_cur && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= idx;
            end
            if (v_cur && rd.pin == 8'd0 && !unp_f) begin
              unp_f   <= 1'b1;
              unp_idx <= idx;
              ud      <= rd;
            end
          end
          // hold on this frame until its write-back is taken
          if (!stall) begin
            if (last_frame) begin
              state <= (cmd_r <= CMD_UNPIN) ? S_DEC : S_FIN;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end
        end
        S_DEC: begin
          case (cmd_r) inside
            CMD_PIN, CMD_ALLOC: begin
              if (hit_f) begin
                frame_r <= hit_idx;
                if (cmd_r == CMD_ALLOC) begin
                  status_r <= ST_INBUF;
                end
                state <= S_FIN;
              end else if (free_f) begin
                victim <= free_idx;
                state  <= S_FILL;
              end else if (unp_f) begin
                victim <= unp_idx;
                if (ud.dirty) begin
                  // write the evicted page back before reuse
                  wb_idx  <= unp_idx;
                  wb_file <= ud.file;
                  wb_page <= ud.page;
                  state   <= S_WB;
                end else begin
                  state <= S_FILL;
                end
              end else begin
                status_r <= ST_NOBUF;
                state    <= S_FIN;
              end
            end
            CMD_DIRTY: begin
              if (!hit_f) begin
                status_r <= ST_NOTINBUF;
              end
              state <= S_FIN;
            end
            CMD_UNPIN: begin
              if (!hit_f) begin
                status_r <= ST_NOTINBUF;
                state    <= S_FIN;
              end else if (pin_dec == 8'd0 && hd.dirty) begin
                wb_idx  <= hit_idx;
                wb_file <= hd.file;
                wb_page <= hd.page;
                state   <= S_WB;
              end else begin
                state <= S_FIN;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_WB: begin
          if (out_free) begin
            state <= (cmd_r == CMD_UNPIN) ? S_FIN : S_FILL;
          end
        end
        S_FILL: begin
          frame_r <= victim;
          state   <= (cmd_r == CMD_PIN) ? S_RQ : S_FIN;
        end
        S_RQ: begin
          if (out_free) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/pfpm_checker.sv =====
// ----------------------------------------------------------------------------
// pfpm_checker
// Port-level checks for the page frame manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfpm_checker import pfpm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result item holds
  `AST_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // one command at a time: busy right after an accept
  `AST_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // requests never close a command and carry status ok
  `AST_IMPL(a_req_fields, clk, rst, m_tvalid && (m_tuser != KIND_FINAL), !m_tlast && (m_tdata[29:28] == ST_OK))

  // every final status closes the command
  `AST_IMPL(a_final_last, clk, rst, m_tvalid && (m_tuser == KIND_FINAL), m_tlast)

endmodule

bind page_frame_pin_manager pfpm_checker u_pfpm_checker (.*);
